// ===== design/psa_pkg.sv =====
// Shared constants, types and the restoring division step for the saturation adjuster.
package psa_pkg;

   localparam int CHAN_W      = 8;
   localparam int K_W         = 9;
   localparam int ALPHA_W     = 16;
   localparam int PROD_W      = CHAN_W + 1 + ALPHA_W;
   localparam int PIX_STAGES  = 9;
   localparam int PIPE_DEPTH  = 11;
   localparam int RSP_LATENCY = PIPE_DEPTH;

   localparam logic signed [7:0] AMOUNT_MAX = 8'sd100;
   localparam logic signed [7:0] AMOUNT_MIN = -8'sd100;
   // Reciprocal of 100/128 scaled by 2**13, rounded up so that the floor is exact.
   localparam logic [13:0] K_RECIP = 14'd10486;
   localparam int K_SHIFT = 13;
   localparam logic [8:0] SUM_FULL = 9'd510;

   typedef struct packed {
      logic [CHAN_W-1:0] blue;
      logic [CHAN_W-1:0] green;
      logic [CHAN_W-1:0] red;
      logic [CHAN_W-1:0] lum;
      logic              pass;
   } pix_type;

   // One restoring division step: returns {quotient bit, new remainder}.
   function automatic logic [8:0] div_step(input logic [7:0] rem, input logic nb,
                                           input logic [7:0] den);
      logic [8:0] trial;
      logic [8:0] diff;
      trial = {rem, nb};
      diff  = trial - {1'b0, den};
      if (trial >= {1'b0, den}) begin
         return {1'b1, diff[7:0]};
      end else begin
         return {1'b0, trial[7:0]};
      end
   endfunction

endpackage

// ===== design/psa_channel.sv =====
// One colour channel: scales its distance from lightness by alpha, then adds and clamps.
module psa_channel (
   input  logic                                clock,
   input  logic [psa_pkg::CHAN_W-1:0]          chan,
   input  logic [psa_pkg::CHAN_W-1:0]          lum,
   input  logic signed [psa_pkg::ALPHA_W-1:0]  alpha,
   input  logic                                pass,
   output logic [psa_pkg::CHAN_W-1:0]          result
);
   import psa_pkg::*;

   logic signed [CHAN_W:0]   diff;
   logic signed [PROD_W-1:0] prod_in, prod_ff;
   logic [CHAN_W-1:0]        chan_ff;
   logic                     pass_ff;
   logic signed [PROD_W:0]   adj;
   logic [CHAN_W-1:0]        result_in, result_ff;

   assign diff    = $signed({1'b0, chan}) - $signed({1'b0, lum});
   assign prod_in = PROD_W'(diff) * PROD_W'(alpha);

   always_ff @(posedge clock) begin
      prod_ff <= prod_in;
      chan_ff <= chan;
      pass_ff <= pass;
   end

   // The arithmetic shift floors negative products, as the scaling requires.
   always_comb begin
      adj = (PROD_W+1)'(prod_ff >>> 7) + (PROD_W+1)'($signed({1'b0, chan_ff}));
      if (pass_ff) begin
         result_in = chan_ff;
      end else if (adj < 0) begin
         result_in = '0;
      end else if (adj > (PROD_W+1)'(255)) begin
         result_in = '1;
      end else begin
         result_in = adj[CHAN_W-1:0];
      end
   end

   always_ff @(posedge clock) begin
      result_ff <= result_in;
   end

   assign result = result_ff;

endmodule

// ===== design/pixel_saturation_adjust.sv =====
// Saturation adjuster for 8-bit RGB pixels, fully pipelined, one pixel per clock.
// Each result is strobed on rsp_valid for one cycle once its transaction has passed
// the eleven register stages (two pipelined dividers among them); throughput is one
// transaction per cycle. busy never rises and the receiver cannot stall. Synchronous
// reset empties the pipeline and sets the saturation amount to zero, so pixels pass
// unchanged.
module pixel_saturation_adjust (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       start,
   output logic                       busy,
   input  logic [psa_pkg::CHAN_W-1:0] req_blue_in,
   input  logic [psa_pkg::CHAN_W-1:0] req_green_in,
   input  logic [psa_pkg::CHAN_W-1:0] req_red_in,
   output logic                       rsp_valid,
   output logic [psa_pkg::CHAN_W-1:0] rsp_blue_out,
   output logic [psa_pkg::CHAN_W-1:0] rsp_green_out,
   output logic [psa_pkg::CHAN_W-1:0] rsp_red_out,
   input  logic                       csr_valid,
   output logic                       csr_ready,
   input  logic signed [7:0]          csr_saturation_amount
);
   import psa_pkg::*;

   // ------------------------------------------------------------------
   // Configuration. The gain k = amount * 128 / 100 (truncated towards
   // zero) is worked out when the register is written, so the pixel
   // path only ever sees k. The amount is first limited to +/-100.
   // ------------------------------------------------------------------
   logic signed [7:0]     amt_lim;
   logic [6:0]            amt_mag;
   logic [20:0]           k_prod;
   logic [7:0]            k_mag;
   logic signed [K_W-1:0] k_in, k_ff;

   always_comb begin
      if (csr_saturation_amount > AMOUNT_MAX) begin
         amt_lim = AMOUNT_MAX;
      end else if (csr_saturation_amount < AMOUNT_MIN) begin
         amt_lim = AMOUNT_MIN;
      end else begin
         amt_lim = csr_saturation_amount;
      end
      amt_mag = amt_lim[7] ? 7'(-amt_lim) : amt_lim[6:0];
      k_prod  = 21'(amt_mag) * 21'(K_RECIP);
      k_mag   = k_prod[K_SHIFT +: 8];
      k_in    = amt_lim[7] ? -$signed({1'b0, k_mag}) : $signed({1'b0, k_mag});
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         k_ff <= '0;
      end else if (csr_valid && csr_ready) begin
         k_ff <= k_in;
      end
   end

   assign csr_ready = 1'b1;

   // The pipeline never stalls, so a new transaction is always welcome.
   assign busy = 1'b0;

   // ------------------------------------------------------------------
   // Valid bits travel alongside the data, one per register stage.
   // ------------------------------------------------------------------
   logic                  accept;
   logic [PIPE_DEPTH-1:0] valid_in, valid_ff;

   assign accept   = start && !busy;
   assign valid_in = {valid_ff[PIPE_DEPTH-2:0], accept};

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   // Pixel, lightness and pass flag ride along until the channel stage.
   pix_type pix_in [2];
   pix_type pix_ff [PIX_STAGES];

   // Stage 0: capture the incoming pixel.
   always_comb begin
      pix_in[0]       = pix_ff[0];
      if (accept) begin
         pix_in[0].blue  = req_blue_in;
         pix_in[0].green = req_green_in;
         pix_in[0].red   = req_red_in;
      end
      pix_in[0].lum   = '0;
      pix_in[0].pass  = 1'b0;
   end

   // Stage 1: extremes, delta, sum, lightness and the first divisor.
   // When lightness is below 128 the divisor is the sum, otherwise
   // 510 - sum; in either case it lies in 1..255 for a coloured pixel.
   logic [CHAN_W-1:0] mn, mx;
   logic [8:0]        sum;
   logic [8:0]        den_full;
   logic [CHAN_W-1:0] delta_in, delta1_ff, den1_ff;

   always_comb begin
      mn = pix_ff[0].red < pix_ff[0].green ? pix_ff[0].red : pix_ff[0].green;
      if (pix_ff[0].blue < mn) begin
         mn = pix_ff[0].blue;
      end
      mx = pix_ff[0].red > pix_ff[0].green ? pix_ff[0].red : pix_ff[0].green;
      if (pix_ff[0].blue > mx) begin
         mx = pix_ff[0].blue;
      end
      delta_in      = mx - mn;
      sum           = {1'b0, mx} + {1'b0, mn};
      pix_in[1]     = pix_ff[0];
      pix_in[1].lum = sum[8:1];
      // A gray pixel, or a gain of zero, leaves the pixel untouched.
      pix_in[1].pass = (k_ff == '0) || (delta_in == '0);
      den_full      = pix_in[1].lum[7] ? SUM_FULL - sum : sum;
   end

   always_ff @(posedge clock) begin
      delta1_ff <= delta_in;
      den1_ff   <= den_full[7:0];
   end

   // Stages 2 and 3: S = (delta << 7) / den, four quotient bits per stage.
   // The quotient never exceeds 128, so eight bits are enough and the
   // upper seven numerator bits form the starting remainder.
   logic [7:0] rem2_in, rem2_ff, den2_ff;
   logic [3:0] qhi_in, qhi2_ff;
   logic [7:0] s_in, s3_ff;

   always_comb begin
      logic [7:0] rem;
      logic [8:0] st;
      rem = {1'b0, delta1_ff[7:1]};
      for (int i = 0; i < 4; i++) begin
         st = div_step(rem, (i == 0) ? delta1_ff[0] : 1'b0, den1_ff);
         qhi_in[3-i] = st[8];
         rem = st[7:0];
      end
      rem2_in = rem;
   end

   always_ff @(posedge clock) begin
      rem2_ff <= rem2_in;
      qhi2_ff <= qhi_in;
      den2_ff <= den1_ff;
   end

   always_comb begin
      logic [7:0] rem;
      logic [8:0] st;
      rem = rem2_ff;
      s_in[7:4] = qhi2_ff;
      for (int i = 0; i < 4; i++) begin
         st = div_step(rem, 1'b0, den2_ff);
         s_in[3-i] = st[8];
         rem = st[7:0];
      end
   end

   always_ff @(posedge clock) begin
      s3_ff <= s_in;
   end

   // Stage 4: second divisor. d = S when k + S reaches 128, else 128 - k;
   // a zero divisor is taken as one. Only a positive gain uses it.
   logic signed [K_W+1:0] k_plus_s;
   logic [7:0]            d_raw;
   logic [7:0]            d_in, d4_ff;

   always_comb begin
      k_plus_s = (K_W+2)'(k_ff) + (K_W+2)'($signed({1'b0, s3_ff}));
      d_raw    = (k_plus_s >= (K_W+2)'(128)) ? s3_ff : 8'((K_W+2)'(128) - (K_W+2)'(k_ff));
      d_in     = (d_raw == '0) ? 8'd1 : d_raw;
   end

   always_ff @(posedge clock) begin
      d4_ff <= d_in;
   end

   // Stages 5 to 8: 16384 / d, fifteen quotient bits over four stages.
   // The numerator has a single one in bit 14, so only the first step
   // brings in a set bit.
   logic [7:0]  rem5_in, rem5_ff, d5_ff;
   logic [3:0]  q5_in, q5_ff;
   logic [7:0]  rem6_in, rem6_ff, d6_ff;
   logic [7:0]  q6_in, q6_ff;
   logic [7:0]  rem7_in, rem7_ff, d7_ff;
   logic [11:0] q7_in, q7_ff;
   logic [14:0] q8;
   logic signed [ALPHA_W-1:0] alpha_in, alpha8_ff;

   always_comb begin
      logic [7:0] rem;
      logic [8:0] st;
      rem = '0;
      for (int i = 0; i < 4; i++) begin
         st = div_step(rem, (i == 0), d4_ff);
         q5_in[3-i] = st[8];
         rem = st[7:0];
      end
      rem5_in = rem;
   end

   always_ff @(posedge clock) begin
      rem5_ff <= rem5_in;
      q5_ff   <= q5_in;
      d5_ff   <= d4_ff;
   end

   always_comb begin
      logic [7:0] rem;
      logic [8:0] st;
      rem = rem5_ff;
      q6_in[7:4] = q5_ff;
      for (int i = 0; i < 4; i++) begin
         st = div_step(rem, 1'b0, d5_ff);
         q6_in[3-i] = st[8];
         rem = st[7:0];
      end
      rem6_in = rem;
   end

   always_ff @(posedge clock) begin
      rem6_ff <= rem6_in;
      q6_ff   <= q6_in;
      d6_ff   <= d5_ff;
   end

   always_comb begin
      logic [7:0] rem;
      logic [8:0] st;
      rem = rem6_ff;
      q7_in[11:4] = q6_ff;
      for (int i = 0; i < 4; i++) begin
         st = div_step(rem, 1'b0, d6_ff);
         q7_in[3-i] = st[8];
         rem = st[7:0];
      end
      rem7_in = rem;
   end

   always_ff @(posedge clock) begin
      rem7_ff <= rem7_in;
      q7_ff   <= q7_in;
      d7_ff   <= d6_ff;
   end

   // Last three quotient bits, then alpha: 16384/d - 128 for a positive
   // gain, the gain itself for a negative one.
   always_comb begin
      logic [7:0] rem;
      logic [8:0] st;
      rem = rem7_ff;
      q8[14:3] = q7_ff;
      for (int i = 0; i < 3; i++) begin
         st = div_step(rem, 1'b0, d7_ff);
         q8[2-i] = st[8];
         rem = st[7:0];
      end
      if (k_ff < 0) begin
         alpha_in = ALPHA_W'(k_ff);
      end else begin
         alpha_in = $signed({1'b0, q8}) - ALPHA_W'(128);
      end
   end

   always_ff @(posedge clock) begin
      alpha8_ff <= alpha_in;
   end

   // The first two stages take the captured and the analysed pixel; after
   // that the pixel record simply follows the divider stages.
   always_ff @(posedge clock) begin
      for (int i = 0; i < 2; i++) begin
         pix_ff[i] <= pix_in[i];
      end
      for (int i = 2; i < PIX_STAGES; i++) begin
         pix_ff[i] <= pix_ff[i-1];
      end
   end

   // Stages 9 and 10: per-channel multiply, then shift, add and clamp.
   psa_channel u_blue (
      .clock  (clock),
      .chan   (pix_ff[PIX_STAGES-1].blue),
      .lum    (pix_ff[PIX_STAGES-1].lum),
      .alpha  (alpha8_ff),
      .pass   (pix_ff[PIX_STAGES-1].pass),
      .result (rsp_blue_out)
   );

   psa_channel u_green (
      .clock  (clock),
      .chan   (pix_ff[PIX_STAGES-1].green),
      .lum    (pix_ff[PIX_STAGES-1].lum),
      .alpha  (alpha8_ff),
      .pass   (pix_ff[PIX_STAGES-1].pass),
      .result (rsp_green_out)
   );

   psa_channel u_red (
      .clock  (clock),
      .chan   (pix_ff[PIX_STAGES-1].red),
      .lum    (pix_ff[PIX_STAGES-1].lum),
      .alpha  (alpha8_ff),
      .pass   (pix_ff[PIX_STAGES-1].pass),
      .result (rsp_red_out)
   );

   assign rsp_valid = valid_ff[PIPE_DEPTH-1];

endmodule

// ===== design/psa_checker.sv =====
// Port-level checks on the saturation adjuster's timing and gray-pixel behaviour.
module psa_checker (
   input logic                       clock,
   input logic                       reset,
   input logic                       start,
   input logic                       busy,
   input logic [psa_pkg::CHAN_W-1:0] req_blue_in,
   input logic [psa_pkg::CHAN_W-1:0] req_green_in,
   input logic [psa_pkg::CHAN_W-1:0] req_red_in,
   input logic                       rsp_valid,
   input logic [psa_pkg::CHAN_W-1:0] rsp_blue_out,
   input logic [psa_pkg::CHAN_W-1:0] rsp_green_out,
   input logic [psa_pkg::CHAN_W-1:0] rsp_red_out
);
   import psa_pkg::*;

   logic accepted;
   logic gray;

   assign accepted = start && !busy;
   assign gray     = (req_blue_in == req_green_in) && (req_green_in == req_red_in);

   // Every accepted transaction produces its result a fixed time later.
   a_result_follows: assert property (@(posedge clock) disable iff (reset)
      accepted |-> ##RSP_LATENCY rsp_valid)
      else $error("accepted transaction produced no result");

   // No result appears without a transaction behind it.
   a_no_invented: assert property (@(posedge clock) disable iff (reset)
      !accepted |-> ##RSP_LATENCY !rsp_valid)
      else $error("result strobed without an accepted transaction");

   // A gray pixel comes back unchanged whatever the saturation amount.
   a_gray_passes: assert property (@(posedge clock) disable iff (reset)
      (accepted && gray) |-> ##RSP_LATENCY
         (rsp_blue_out == $past(req_blue_in, RSP_LATENCY)) &&
         (rsp_green_out == $past(req_green_in, RSP_LATENCY)) &&
         (rsp_red_out == $past(req_red_in, RSP_LATENCY)))
      else $error("gray pixel was altered");

   // Reset empties the pipeline.
   a_reset_clears: assert property (@(posedge clock)
      $past(reset) |-> !rsp_valid)
      else $error("result strobed straight after reset");

endmodule

bind pixel_saturation_adjust psa_checker u_psa_checker (.*);

// ===== tb/tb_top.sv =====
// Self-checking testbench for the pixel saturation adjuster, with its scoreboard class.
module tb_top;
   timeunit 1ns;
   timeprecision 1ps;

   import psa_pkg::*;

   // One pixel as it crosses either side of the block.
   typedef struct packed {
      logic [CHAN_W-1:0] blue;
      logic [CHAN_W-1:0] green;
      logic [CHAN_W-1:0] red;
   } rgb_type;

   // The scoreboard keeps its own copy of the saturation amount. It works out the adjusted
   // pixel for every accepted transaction and holds those pixels in arrival order until the
   // matching result transaction shows up on the response side.
   class saturation_scoreboard;
      logic signed [7:0] amount;
      rgb_type           expected_pixels[$];
      int                mismatches;
      int                checked;

      function new();
         amount     = '0;
         mismatches = 0;
         checked    = 0;
      endfunction

      // Moves one channel away from (or towards) the lightness and clamps it to 0..255.
      // The shift is arithmetic, so negative products round towards minus infinity.
      function logic [CHAN_W-1:0] adjust_channel(int c, int lum, int alpha);
         int v;
         v = c + (((c - lum) * alpha) >>> 7);
         if (v < 0) begin
            return '0;
         end else if (v > 255) begin
            return 8'd255;
         end
         return v[CHAN_W-1:0];
      endfunction

      function rgb_type adjust_pixel(rgb_type px);
         int      s, k, b, g, r, mn, mx, delta, sum, lum, sat, d, alpha;
         rgb_type res;
         b = int'(px.blue);
         g = int'(px.green);
         r = int'(px.red);
         s = int'(amount);
         if (s < int'(AMOUNT_MIN)) s = int'(AMOUNT_MIN);
         if (s > int'(AMOUNT_MAX)) s = int'(AMOUNT_MAX);
         // Integer division truncates towards zero, as the gain requires.
         k  = (s * 128) / 100;
         mn = (r < g) ? r : g;
         if (b < mn) mn = b;
         mx = (r > g) ? r : g;
         if (b > mx) mx = b;
         delta = mx - mn;
         sum   = mx + mn;
         // A gray pixel or a zero gain leaves the pixel as it is.
         if (k == 0 || delta == 0) begin
            return px;
         end
         lum = sum >> 1;
         if (lum < 128) begin
            sat = (delta * 128) / sum;
         end else begin
            sat = (delta * 128) / (510 - sum);
         end
         if (k > 0) begin
            d = (k + sat >= 128) ? sat : 128 - k;
            // Full gain on an almost gray pixel would divide by zero; the divisor becomes one.
            if (d == 0) d = 1;
            alpha = 16384 / d - 128;
         end else begin
            alpha = k;
         end
         res.blue  = adjust_channel(b, lum, alpha);
         res.green = adjust_channel(g, lum, alpha);
         res.red   = adjust_channel(r, lum, alpha);
         return res;
      endfunction

      function void note_pixel(rgb_type px);
         expected_pixels.push_back(adjust_pixel(px));
      endfunction

      function void compare_field(string name, logic [CHAN_W-1:0] want, logic [CHAN_W-1:0] got);
         if (got !== want) begin
            $error("%s: expected %0d, got %0d", name, want, got);
            mismatches++;
         end
      endfunction

      function void check_pixel(rgb_type px);
         rgb_type want;
         if (expected_pixels.size() == 0) begin
            $error("result transaction with no pixel outstanding: blue %0d green %0d red %0d",
                   px.blue, px.green, px.red);
            mismatches++;
            return;
         end
         want = expected_pixels.pop_front();
         compare_field("blue_out", want.blue, px.blue);
         compare_field("green_out", want.green, px.green);
         compare_field("red_out", want.red, px.red);
         checked++;
      endfunction

      function int pending();
         return expected_pixels.size();
      endfunction
   endclass

   // Run length: roughly 780 transactions with random idle gaps between them, plus the
   // drains before every amount change. A few tens of microseconds at most; this is ample.
   localparam int RUN_LIMIT_NS = 2_000_000;
   localparam int SEGMENTS     = 12;
   localparam int SEG_ITEMS    = 63;

   logic                    clock;
   logic                    reset;
   logic                    start;
   logic                    busy;
   logic [CHAN_W-1:0]       req_blue_in;
   logic [CHAN_W-1:0]       req_green_in;
   logic [CHAN_W-1:0]       req_red_in;
   logic                    rsp_valid;
   logic [CHAN_W-1:0]       rsp_blue_out;
   logic [CHAN_W-1:0]       rsp_green_out;
   logic [CHAN_W-1:0]       rsp_red_out;
   logic                    csr_valid;
   logic                    csr_ready;
   logic signed [7:0]       csr_saturation_amount;

   saturation_scoreboard sb;
   int                   pixels_sent;
   int                   amounts_written;

   pixel_saturation_adjust dut (
      .clock                 (clock),
      .reset                 (reset),
      .start                 (start),
      .busy                  (busy),
      .req_blue_in           (req_blue_in),
      .req_green_in          (req_green_in),
      .req_red_in            (req_red_in),
      .rsp_valid             (rsp_valid),
      .rsp_blue_out          (rsp_blue_out),
      .rsp_green_out         (rsp_green_out),
      .rsp_red_out           (rsp_red_out),
      .csr_valid             (csr_valid),
      .csr_ready             (csr_ready),
      .csr_saturation_amount (csr_saturation_amount)
   );

   initial clock = 1'b0;
   always begin
      #4 clock = 1'b1;
      #4 clock = 1'b0;
   end

   // Results are sampled on the rising edge, before the design's registers move. The
   // receiver can never push back, so every strobed cycle is a completed transaction.
   always @(posedge clock) begin
      if (!reset && rsp_valid === 1'b1) begin
         sb.check_pixel('{blue: rsp_blue_out, green: rsp_green_out, red: rsp_red_out});
      end
   end

   // A channel value a little above the base, held at the top rail.
   function automatic logic [CHAN_W-1:0] near_value(int base, int spread);
      int v;
      v = base + int'($urandom_range(spread));
      return (v > 255) ? 8'd255 : v[CHAN_W-1:0];
   endfunction

   // Presents one pixel from the falling edge and holds it until the block takes it. start
   // is left high afterwards so that back-to-back transactions need no gap.
   task automatic send_pixel(rgb_type px);
      @(negedge clock);
      start        = 1'b1;
      req_blue_in  = px.blue;
      req_green_in = px.green;
      req_red_in   = px.red;
      @(posedge clock);
      while (busy !== 1'b0) @(posedge clock);
      sb.note_pixel(px);
      pixels_sent++;
   endtask

   // Idles the request side for a random number of cycles; on average pct cycles in a
   // hundred are idle. The data lines carry noise meanwhile, which the block must ignore.
   task automatic sender_pause(int pct);
      while ($urandom_range(99) < pct) begin
         @(negedge clock);
         start        = 1'b0;
         req_blue_in  = 8'($urandom_range(255));
         req_green_in = 8'($urandom_range(255));
         req_red_in   = 8'($urandom_range(255));
         @(posedge clock);
      end
   endtask

   // Stops sending and waits until every outstanding pixel has come back. Each pixel yields
   // exactly one result, so an empty scoreboard means an empty pipeline.
   task automatic drain_pipeline();
      @(negedge clock);
      start = 1'b0;
      @(posedge clock);
      while (sb.pending() != 0) @(posedge clock);
   endtask

   // Changes the amount only once the pipeline is empty, so no pixel in flight sees it.
   task automatic set_saturation(logic signed [7:0] value);
      drain_pipeline();
      @(negedge clock);
      csr_valid             = 1'b1;
      csr_saturation_amount = value;
      @(posedge clock);
      while (csr_ready !== 1'b1) @(posedge clock);
      sb.amount = value;
      amounts_written++;
      @(negedge clock);
      csr_valid = 1'b0;
   endtask

   initial begin
      rgb_type           directed[12];
      logic signed [7:0] seg_amount[SEGMENTS];
      int                sender_pct[4];
      rgb_type           px;
      int                kind;
      int                base;
      int                spread;

      sb              = new();
      pixels_sent     = 0;
      amounts_written = 0;

      reset                 = 1'b1;
      start                 = 1'b0;
      req_blue_in           = '0;
      req_green_in          = '0;
      req_red_in            = '0;
      csr_valid             = 1'b0;
      csr_saturation_amount = '0;

      // Corners: black, white, a gray, the primaries and a secondary, two near-gray pixels
      // either side of mid lightness (with full gain these hit the zero divisor), single-step
      // differences at both ends of the range and one strongly coloured pixel.
      directed[0]  = '{blue: 8'd0,   green: 8'd0,   red: 8'd0};
      directed[1]  = '{blue: 8'd255, green: 8'd255, red: 8'd255};
      directed[2]  = '{blue: 8'd77,  green: 8'd77,  red: 8'd77};
      directed[3]  = '{blue: 8'd0,   green: 8'd0,   red: 8'd255};
      directed[4]  = '{blue: 8'd0,   green: 8'd255, red: 8'd0};
      directed[5]  = '{blue: 8'd255, green: 8'd0,   red: 8'd0};
      directed[6]  = '{blue: 8'd0,   green: 8'd255, red: 8'd255};
      directed[7]  = '{blue: 8'd127, green: 8'd127, red: 8'd128};
      directed[8]  = '{blue: 8'd128, green: 8'd128, red: 8'd129};
      directed[9]  = '{blue: 8'd1,   green: 8'd0,   red: 8'd0};
      directed[10] = '{blue: 8'd255, green: 8'd254, red: 8'd255};
      directed[11] = '{blue: 8'd100, green: 8'd10,  red: 8'd200};

      // Amounts for the random segments: both limits, the smallest steps, the raw register
      // extremes and just beyond the limits (which the block must saturate), zero, 85, and two
      // drawn at random over the whole register.
      seg_amount = '{8'sd100, -8'sd100, 8'sd1, -8'sd1, 8'sd127, -8'sd128, 8'sd0,
                     8'sd101, -8'sd101, 8'sd85, 8'sd0, 8'sd0};
      seg_amount[10] = 8'($urandom_range(255));
      seg_amount[11] = 8'($urandom_range(255));

      // Sender idling per phase: none, heavy, none again, light.
      sender_pct = '{0, 58, 0, 21};

      repeat (8) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      // Directed part. The amount is still at its reset value, so pixels must pass unchanged.
      for (int i = 0; i < 3; i++) send_pixel(directed[i]);
      set_saturation(8'sd100);
      for (int i = 0; i < 12; i++) send_pixel(directed[i]);
      set_saturation(-8'sd100);
      for (int i = 3; i < 9; i++) send_pixel(directed[i]);
      set_saturation(8'sd127);
      send_pixel(directed[7]);
      send_pixel(directed[11]);
      set_saturation(-8'sd128);
      send_pixel(directed[11]);
      send_pixel(directed[3]);

      // Random part, one amount per segment and the idling phases in rotation.
      for (int seg = 0; seg < SEGMENTS; seg++) begin
         set_saturation(seg_amount[seg]);
         for (int i = 0; i < SEG_ITEMS; i++) begin
            kind = $urandom_range(99);
            if (kind < 55) begin
               px = '{blue: 8'($urandom_range(255)), green: 8'($urandom_range(255)),
                      red: 8'($urandom_range(255))};
            end else if (kind < 80) begin
               // Nearly gray: small spread around a random base, where saturation is tiny.
               base     = $urandom_range(255);
               spread   = $urandom_range(3);
               px.blue  = near_value(base, spread);
               px.green = near_value(base, spread);
               px.red   = near_value(base, spread);
            end else if (kind < 88) begin
               base = $urandom_range(255);
               px   = '{blue: 8'(base), green: 8'(base), red: 8'(base)};
            end else begin
               // Channels at the rails, which push the clamp hardest.
               px.blue  = $urandom_range(1) ? 8'd255 : 8'd0;
               px.green = $urandom_range(1) ? 8'd255 : 8'($urandom_range(255));
               px.red   = $urandom_range(1) ? 8'd0   : 8'($urandom_range(255));
            end
            send_pixel(px);
            sender_pause(sender_pct[seg % 4]);
            // Now and then stop mid-segment until the pipeline has emptied completely.
            if (seg % 3 == 1 && i == SEG_ITEMS / 2) drain_pipeline();
         end
      end

      drain_pipeline();
      // Some extra cycles to catch any stray result strobe.
      repeat (RSP_LATENCY + 4) @(posedge clock);

      $display("Sent %0d pixels under %0d saturation amounts (limits, register extremes, zero).",
               pixels_sent, amounts_written + 1);
      $display("Checked %0d results, %0d mismatches, %0d left outstanding.",
               sb.checked, sb.mismatches, sb.pending());
      if (sb.mismatches == 0 && sb.pending() == 0) begin
         $display("simulation ok");
      end else begin
         $display("simulation failed");
      end
      $finish;
   end

   initial begin
      #(RUN_LIMIT_NS);
      $display("Run limit reached with %0d results outstanding.", sb.pending());
      $display("simulation failed");
      $finish;
   end

endmodule
